@@ rtl/rid_pkg.sv @@
// Shared types, sizes and codes of the rotating id allocator.
`default_nettype none

package rid_pkg;

   localparam int NUM_SLOTS = 32;
   localparam int ID_BITS   = 16;
   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MAX_TRIES = 2 * NUM_SLOTS + 1;
   localparam int TRY_BITS  = $clog2(MAX_TRIES + 1);

   localparam logic [15:0] MAX_ID_RESET  = 16'd30000;
   localparam logic [15:0] BASE_ID_RESET = 16'd1;
   localparam logic [ID_BITS-1:0] CAND_RESET = ID_BITS'(17'(BASE_ID_RESET) + 17'd1);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FIND  = 2'd2;

   localparam logic CSR_MAX_ID  = 1'b0;
   localparam logic CSR_BASE_ID = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  slot_index;
      logic [15:0] id_value;
      logic [15:0] group_value;
      logic        in_use;
   } req_type;

   typedef struct packed {
      logic [15:0] result_id;
      logic        found;
      logic [4:0]  result_slot;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_id;
      logic [15:0] base_id;
   } cfg_type;

   typedef struct packed {
      logic               used;
      logic [ID_BITS-1:0] id;
      logic [ID_BITS-1:0] group;
   } slot_entry_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] index;
      slot_entry_type       entry;
   } table_wr_type;

endpackage

`default_nettype wire

@@ rtl/rotating_id_allocator.sv @@
// Top level of the rotating id allocator: control registers and the scan engine.
//
//   channel  ports                              handshake
//   -------  ---------------------------------  ----------------------------------
//   request  start, busy, req_data              beat taken when start && !busy
//   result   rsp_valid, rsp_data                one-cycle strobe, cannot be held off
//   control  csr_we, csr_index, csr_wdata       write taken when csr_we is high
//
// A write (or unused mode) beat leaves the sequencer idle; its result appears the next cycle.
// Find compares one slot a cycle from slot 0 on and stops at the first hit or after the last slot.
// Allocate steps to each new candidate in an advance state, then compares it with one slot
// a cycle until a slot blocks it or all slots pass; it tries at most 2*NUM_SLOTS+1 candidates.
// The single slot comparator under the scan sequencer sets this one-slot-a-cycle pace.
// Reset clears the slot table, loads the register defaults and the first candidate.
`default_nettype none

module rotating_id_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rid_pkg::req_type req_data,
   output logic                  rsp_valid,
   output rid_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import rid_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   table_wr_type         tbl_wr;
   logic [SLOT_BITS-1:0] tbl_index;
   slot_entry_type       tbl_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ID:  cfg_in.max_id  = csr_wdata;
            CSR_BASE_ID: cfg_in.base_id = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_id  <= MAX_ID_RESET;
         cfg_ff.base_id <= BASE_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rid_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_index (tbl_index),
      .rd_entry (tbl_entry)
   );

   rid_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .tbl_wr    (tbl_wr),
      .tbl_index (tbl_index),
      .tbl_entry (tbl_entry),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/rid_table.sv @@
// Slot table: one write port and one read port at the scan index.
`default_nettype none

module rid_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rid_pkg::table_wr_type        wr,
   input  wire logic [rid_pkg::SLOT_BITS-1:0] rd_index,
   output rid_pkg::slot_entry_type           rd_entry
);
   import rid_pkg::*;

   slot_entry_type slots_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slots_ff[s] <= '0;
         end
      end else if (wr.en) begin
         slots_ff[wr.index] <= wr.entry;
      end
   end

   assign rd_entry = slots_ff[rd_index];

endmodule

`default_nettype wire

@@ rtl/rid_scan.sv @@
// Sequencer with the shared slot comparator for allocate and find.
`default_nettype none

module rid_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rid_pkg::cfg_type              cfg,
   input  wire logic                          start,
   input  wire rid_pkg::req_type              req_data,
   output logic                               busy,
   output rid_pkg::table_wr_type              tbl_wr,
   output logic [rid_pkg::SLOT_BITS-1:0]      tbl_index,
   input  wire rid_pkg::slot_entry_type       tbl_entry,
   output logic                               rsp_valid,
   output rid_pkg::rsp_type                   rsp_data
);
   import rid_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ADVANCE = 4'b0010,
      ST_ALLOC   = 4'b0100,
      ST_FIND    = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [TRY_BITS-1:0]  tries_ff, tries_in;
   logic [ID_BITS-1:0]   cand_ff, cand_in;
   logic [ID_BITS-1:0]   key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 last_slot;
   logic [ID_BITS-1:0]   cmp_key;
   logic                 id_hit;
   logic                 group_hit;
   logic [ID_BITS-1:0]   cand_step;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign last_slot = (idx_ff == SLOT_BITS'(NUM_SLOTS - 1));

   // The one comparator serves both scans: the candidate when allocating,
   // the query id when finding.
   assign cmp_key   = (state_ff == ST_FIND) ? key_ff : cand_ff;
   assign id_hit    = (tbl_entry.id == cmp_key);
   assign group_hit = (tbl_entry.group == cmp_key);
   assign tbl_index = idx_ff;

   always_comb begin
      if (33'(cand_ff) < 33'(cfg.max_id)) begin
         cand_step = cand_ff + ID_BITS'(1);
      end else begin
         cand_step = ID_BITS'(17'(cfg.base_id) + 17'd1);
      end
   end

   always_comb begin
      tbl_wr.en          = accept && (req_data.mode == MODE_WRITE) &&
                           (32'(req_data.slot_index) < 32'(NUM_SLOTS));
      tbl_wr.index       = SLOT_BITS'(req_data.slot_index);
      tbl_wr.entry.used  = req_data.in_use;
      tbl_wr.entry.id    = ID_BITS'(req_data.id_value);
      tbl_wr.entry.group = ID_BITS'(req_data.group_value);
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      tries_in     = tries_ff;
      cand_in      = cand_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_ALLOC: begin
                     tries_in = '0;
                     state_in = ST_ADVANCE;
                  end
                  MODE_FIND: begin
                     key_in   = ID_BITS'(req_data.id_value);
                     idx_in   = '0;
                     state_in = ST_FIND;
                  end
                  default: begin
                     // A write, or the unused mode, answers with all zeros.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ADVANCE: begin
            cand_in  = cand_step;
            tries_in = tries_ff + TRY_BITS'(1);
            idx_in   = '0;
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            if (id_hit || group_hit) begin
               if (tries_ff == TRY_BITS'(MAX_TRIES)) begin
                  // Every candidate tried so far was blocked: give up.
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_ADVANCE;
               end
            end else if (last_slot) begin
               rsp_valid_in     = 1'b1;
               rsp_in.found     = 1'b1;
               rsp_in.result_id = 16'(cand_ff);
               state_in         = ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         ST_FIND: begin
            if (tbl_entry.used && id_hit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.result_slot = 5'(idx_ff);
               state_in           = ST_IDLE;
            end else if (last_slot) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         tries_ff     <= '0;
         cand_ff      <= CAND_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tries_ff     <= tries_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result beat only follows the end of an item, so the sequencer is idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result beat while the sequencer is busy");

   // Each new candidate is checked from the first slot on.
   a_scan_from_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADVANCE |=> idx_ff == '0 && state_ff == ST_ALLOC)
      else $error("candidate scan did not start at slot zero");

   a_tries_bound: assert property (@(posedge clock) disable iff (reset)
      tries_ff <= TRY_BITS'(MAX_TRIES))
      else $error("allocation tried too many candidates");

   // Find reports a slot and allocate reports an id, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_slot != 5'd0 |-> rsp_ff.result_id == 16'd0)
      else $error("result carries both a slot and an id");

endmodule

`default_nettype wire

@@ bench/rotating_id_allocator_tb.sv @@
// Self-checking testbench for the rotating id allocator: directed and random request traffic.
`timescale 1ns / 1ps

module rotating_id_allocator_tb;
   import rid_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Shadow copy of the slot table, the candidate and the registers.
   logic [15:0] tbl_id    [NUM_SLOTS] = '{default: '0};
   logic [15:0] tbl_group [NUM_SLOTS] = '{default: '0};
   logic        tbl_used  [NUM_SLOTS] = '{default: 1'b0};
   logic [15:0] cand     = CAND_RESET;
   logic [15:0] cfg_max  = MAX_ID_RESET;
   logic [15:0] cfg_base = BASE_ID_RESET;

   rsp_type     rsp_due [$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int unsigned burst_left = 0;

   rotating_id_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Updates the shadow table and returns the result the block owes for one request.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type o;
      logic    taken;
      o = '0;
      case (r.mode)
         MODE_WRITE: begin
            tbl_id[r.slot_index]    = r.id_value;
            tbl_group[r.slot_index] = r.group_value;
            tbl_used[r.slot_index]  = r.in_use;
         end
         MODE_ALLOC: begin
            for (int t = 0; t < MAX_TRIES; t++) begin
               cand = (cand < cfg_max) ? cand + 16'd1 : cfg_base + 16'd1;
               taken = 1'b0;
               // Every slot blocks its id and group id, in use or not.
               for (int s = 0; s < NUM_SLOTS; s++)
                  if (tbl_id[s] == cand || tbl_group[s] == cand) taken = 1'b1;
               if (!taken) begin
                  o.result_id = cand;
                  o.found     = 1'b1;
                  break;
               end
            end
         end
         MODE_FIND: begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (tbl_used[s] && tbl_id[s] == r.id_value) begin
                  o.found       = 1'b1;
                  o.result_slot = 5'(s);
                  break;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(input logic [1:0] mode, input int slot,
                                        input logic [15:0] id, input logic [15:0] grp,
                                        input logic used);
      req_type r;
      r.mode        = mode;
      r.slot_index  = 5'(slot);
      r.id_value    = id;
      r.group_value = grp;
      r.in_use      = used;
      return r;
   endfunction

   function automatic req_type any_request();
      return make_req(2'($urandom_range(0, 3)), $urandom_range(0, NUM_SLOTS - 1),
                      16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
   endfunction

   // Ids that collide often (near the candidate, in and around the id window, or already stored), plus random ids.
   function automatic logic [15:0] likely_id();
      int unsigned span;
      span = (cfg_max > cfg_base) ? int'(cfg_max - cfg_base) : 3;
      if (span > 60) span = 60;
      case ($urandom_range(0, 9))
         0, 1:    return 16'($urandom);
         2, 3, 4: return tbl_id[$urandom_range(0, NUM_SLOTS - 1)];
         5, 6:    return cand + 16'($urandom_range(0, 12)) - 16'd2;
         default: return cfg_base + 16'($urandom_range(0, span + 1));
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r = any_request();
      pick = $urandom_range(0, 99);
      if (pick < 6) return r;
      r.mode        = (pick < 50) ? MODE_WRITE : (pick < 76) ? MODE_ALLOC : MODE_FIND;
      r.id_value    = likely_id();
      r.group_value = likely_id();
      r.in_use      = ($urandom_range(0, 3) != 0);
      return r;
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   // Sends one request beat and leaves start high unless the burst ends here with a gap.
   task automatic send_request(input req_type item);
      int unsigned gap;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      rsp_due.push_back(apply_request(item));
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
         if (gap != 0) begin
            start    <= 1'b0;
            req_data <= any_request();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (rsp_due.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic program_ids(input logic [15:0] max_v, input logic [15:0] base_v);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_ID;
      csr_wdata <= max_v;
      @(posedge clock);
      csr_index <= CSR_BASE_ID;
      csr_wdata <= base_v;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_max  = max_v;
      cfg_base = base_v;
   endtask

   task automatic test_reset_state();
      send_request(make_req(MODE_FIND, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_UNUSED, 31, 16'hFFFF, 16'hFFFF, 1'b1));
   endtask

   task automatic test_slot_table();
      // A slot that is not in use still blocks its ids for allocation.
      send_request(make_req(MODE_WRITE, 31, 16'd4, 16'd5, 1'b0));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_FIND, 0, 16'd4, 16'd0, 1'b0));
      send_request(make_req(MODE_WRITE, 0, 16'hFFFF, 16'hFFFF, 1'b1));
      send_request(make_req(MODE_WRITE, 7, 16'hFFFF, 16'd7, 1'b1));
      send_request(make_req(MODE_FIND, 0, 16'hFFFF, 16'd0, 1'b0));
      send_request(make_req(MODE_WRITE, 0, 16'hFFFF, 16'hFFFF, 1'b0));
      send_request(make_req(MODE_FIND, 0, 16'hFFFF, 16'd0, 1'b0));
      send_request(make_req(MODE_FIND, 0, 16'd0, 16'd0, 1'b0));
   endtask

   task automatic test_candidate_wrap();
      // Ids 1 to 3 all blocked: the candidate cycles and allocation fails.
      program_ids(16'd3, 16'd0);
      send_request(make_req(MODE_WRITE, 3, 16'd1, 16'd2, 1'b1));
      send_request(make_req(MODE_WRITE, 4, 16'd3, 16'd3, 1'b0));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_WRITE, 4, 16'hABCD, 16'h5432, 1'b1));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      // With max_id below base_id the candidate sticks at base_id plus one.
      program_ids(16'd3, 16'd65533);
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      program_ids(16'hFFFF, 16'd65533);
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
      // base_id plus one wraps to zero, which the cleared slots block.
      program_ids(16'd0, 16'hFFFF);
      send_request(make_req(MODE_ALLOC, 0, 16'd0, 16'd0, 1'b0));
   endtask

   task automatic test_random_traffic(input logic [15:0] max_v, input logic [15:0] base_v,
                                      input int count);
      program_ids(max_v, base_v);
      repeat (count) send_request(random_request());
   endtask

   // Result beats cannot be held off, so each one is checked at the edge that takes it.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (rsp_due.size() == 0) begin
            note_error($sformatf("unexpected result beat: id %0d found %0d slot %0d",
                                 rsp_data.result_id, rsp_data.found, rsp_data.result_slot));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_data.result_id !== want.result_id)
               note_error($sformatf("result_id: expected %0d, got %0d",
                                    want.result_id, rsp_data.result_id));
            if (rsp_data.found !== want.found)
               note_error($sformatf("found: expected %0d, got %0d",
                                    want.found, rsp_data.found));
            if (rsp_data.result_slot !== want.result_slot)
               note_error($sformatf("result_slot: expected %0d, got %0d",
                                    want.result_slot, rsp_data.result_slot));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_MAX_ID;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_slot_table();
      test_candidate_wrap();
      test_random_traffic(16'd40, 16'd10, 600);
      test_random_traffic(16'd3, 16'd0, 150);
      test_random_traffic(16'hFFFF, 16'd65533, 250);
      test_random_traffic(MAX_ID_RESET, BASE_ID_RESET, 400);
      test_random_traffic(16'd100, 16'd200, 150);
      test_random_traffic(16'd1000, 16'd900, 150);

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rid_pkg.sv
rtl/rid_table.sv
rtl/rid_scan.sv
rtl/rotating_id_allocator.sv
bench/rotating_id_allocator_tb.sv
